// ===== rtl/ntc_pkg.sv =====
// Shared constants, types and register codes for the NTC table interpolator.
package ntc_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ADC_BITS_DEF    = 10;

    localparam int OFFSET_W   = 12;
    localparam int STEP_W     = 10;
    localparam int EU_W       = 6;
    localparam int TIDX_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int TEMP_W     = 16;

    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = (STEP_W + DIV_BPS - 1) / DIV_BPS;

    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = '0;
    localparam logic [STEP_W-1:0]          STEP_RST   = 10'd50;
    localparam logic [EU_W-1:0]            EU_RST     = 6'd32;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_OFFSET  = 2'd0,
        CFG_TEMP_STEP    = 2'd1,
        CFG_ENTRIES_USED = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_CONVERT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset;
        logic [STEP_W-1:0]          step;
        logic [EU_W-1:0]            entries;
    } t_cfg;

endpackage

// ===== rtl/ntc_search.sv =====
// Calibration table storage and first-entry search with neighbor fetch.
module ntc_search
    import ntc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load_en,
    input  logic [TIDX_W-1:0]   i_load_index,
    input  logic [ADC_BITS-1:0] i_load_value,
    input  logic                i_conv_valid,
    input  logic [ADC_BITS-1:0] i_sample,
    input  t_cfg                i_cfg,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [IDX_W-1:0]    o_index,
    output logic [ADC_BITS-1:0] o_hi,
    output logic [ADC_BITS-1:0] o_lo,
    output logic [ADC_BITS-1:0] o_sample,
    output logic                o_oor
);

    localparam int AW = (IDX_W > TIDX_W) ? IDX_W : TIDX_W;
    localparam int CW = ((EU_W > IDX_W) ? EU_W : IDX_W) + 2;

    logic [ADC_BITS-1:0] r_table [TABLE_DEPTH];
    logic [AW-1:0]       load_addr;
    logic                load_hit;

    logic                r_s1_valid;
    logic [ADC_BITS-1:0] r_s1_sample;

    logic [TABLE_DEPTH-1:0] used;
    logic [TABLE_DEPTH-1:0] ge;
    logic [TABLE_DEPTH-1:0] first;
    logic [ADC_BITS-1:0]    n_hi;
    logic [ADC_BITS-1:0]    n_lo;
    logic [IDX_W-1:0]       n_idx;
    logic                   n_oor;

    logic                r_s2_valid;
    logic [IDX_W-1:0]    r_s2_index;
    logic [ADC_BITS-1:0] r_s2_hi;
    logic [ADC_BITS-1:0] r_s2_lo;
    logic [ADC_BITS-1:0] r_s2_sample;
    logic                r_s2_oor;
    logic                s2_free;

    assign load_addr = AW'(i_load_index);
    assign load_hit  = i_load_en && ({1'b0, load_addr} < (AW + 1)'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (!i_rst_n) begin
                r_table[k] <= '0;
            end else if (load_hit && (load_addr == AW'(k))) begin
                r_table[k] <= i_load_value;
            end
        end
    end

    assign s2_free = !r_s2_valid || i_ready;
    assign o_ready = !r_s1_valid || s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_conv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_conv_valid) begin
            r_s1_sample <= i_sample;
        end
    end

    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            used[k] = CW'(i_cfg.entries) > CW'(k);
            ge[k]   = used[k] && (r_s1_sample >= r_table[k]);
        end
    end

    // isolate the lowest qualifying entry
    assign first = ge & (~ge + TABLE_DEPTH'(1));

    always_comb begin
        n_hi  = '0;
        n_lo  = '0;
        n_idx = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (first[k]) begin
                n_lo  = n_lo | r_table[k];
                n_idx = n_idx | IDX_W'(k);
            end
        end
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if (first[k]) begin
                n_hi = n_hi | r_table[k-1];
            end
        end
        n_oor = (ge == '0) || first[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_s2_index  <= n_idx;
            r_s2_hi     <= n_hi;
            r_s2_lo     <= n_lo;
            r_s2_sample <= r_s1_sample;
            r_s2_oor    <= n_oor;
        end
    end

    assign o_valid  = r_s2_valid;
    assign o_index  = r_s2_index;
    assign o_hi     = r_s2_hi;
    assign o_lo     = r_s2_lo;
    assign o_sample = r_s2_sample;
    assign o_oor    = r_s2_oor;

endmodule

// ===== rtl/ntc_div.sv =====
// Pipelined restoring divider producing a quotient known to fit STEP_W bits.
module ntc_div
    import ntc_pkg::*;
#(
    parameter int DEN_W  = ADC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [DEN_W+STEP_W-1:0]   i_dividend,
    input  logic [DEN_W-1:0]          i_divisor,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [STEP_W-1:0]         o_quot,
    output logic [SIDE_W-1:0]         o_side
);

    logic                r_v    [DIV_STAGES];
    logic [DEN_W-1:0]    r_rem  [DIV_STAGES];
    logic [DEN_W-1:0]    r_den  [DIV_STAGES];
    logic [STEP_W-1:0]   r_low  [DIV_STAGES];
    logic [STEP_W-1:0]   r_q    [DIV_STAGES];
    logic [SIDE_W-1:0]   r_side [DIV_STAGES];

    logic                st_v    [DIV_STAGES];
    logic [DEN_W-1:0]    st_rem  [DIV_STAGES];
    logic [DEN_W-1:0]    st_den  [DIV_STAGES];
    logic [STEP_W-1:0]   st_low  [DIV_STAGES];
    logic [STEP_W-1:0]   st_q    [DIV_STAGES];
    logic [SIDE_W-1:0]   st_side [DIV_STAGES];

    logic                free   [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            logic [DEN_W-1:0]  n_rem;
            logic [STEP_W-1:0] n_low;
            logic [STEP_W-1:0] n_q;

            if (s == 0) begin : g_head
                assign st_v[s]    = i_valid;
                assign st_rem[s]  = i_dividend[DEN_W+STEP_W-1:STEP_W];
                assign st_den[s]  = i_divisor;
                assign st_low[s]  = i_dividend[STEP_W-1:0];
                assign st_q[s]    = '0;
                assign st_side[s] = i_side;
            end else begin : g_body
                assign st_v[s]    = r_v[s-1];
                assign st_rem[s]  = r_rem[s-1];
                assign st_den[s]  = r_den[s-1];
                assign st_low[s]  = r_low[s-1];
                assign st_q[s]    = r_q[s-1];
                assign st_side[s] = r_side[s-1];
            end

            if (s == DIV_STAGES - 1) begin : g_last
                assign free[s] = !r_v[s] || i_ready;
            end else begin : g_mid
                assign free[s] = !r_v[s] || free[s+1];
            end

            always_comb begin
                logic [DEN_W:0] trial;
                n_rem = st_rem[s];
                n_low = st_low[s];
                n_q   = st_q[s];
                for (int b = 0; b < DIV_BPS; b++) begin
                    if ((s * DIV_BPS + b) < STEP_W) begin
                        trial = {n_rem, n_low[STEP_W-1]};
                        n_low = n_low << 1;
                        if (trial >= {1'b0, st_den[s]}) begin
                            trial = trial - {1'b0, st_den[s]};
                            n_q   = {n_q[STEP_W-2:0], 1'b1};
                        end else begin
                            n_q   = {n_q[STEP_W-2:0], 1'b0};
                        end
                        n_rem = trial[DEN_W-1:0];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (free[s]) begin
                    r_v[s] <= st_v[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (free[s] && st_v[s]) begin
                    r_rem[s]  <= n_rem;
                    r_den[s]  <= st_den[s];
                    r_low[s]  <= n_low;
                    r_q[s]    <= n_q;
                    r_side[s] <= st_side[s];
                end
            end
        end
    endgenerate

    assign o_ready = free[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quot  = r_q[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

// ===== rtl/ntc_table_interpolator_unit.sv =====
// NTC thermistor table interpolator: ADC sample to temperature in tenths of a degree.
//
// Input channel (i_in_valid / o_in_stall) carries one word per item: i_cmd selects a
// table load (i_table_index, i_table_value) or a conversion of i_adc_sample. A load
// writes the calibration table at the accepting edge and gives no result word; a
// load beyond the table depth is dropped. A conversion gives one result word on the
// output channel (o_out_valid / i_out_stall): o_temperature_tenths, saturated to
// 16-bit signed, and o_out_of_range, with the temperature held at zero when set.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0 temp offset, 1 temp step, 2 entries used); write only while the unit is idle.
// Pipeline: input stage, parallel table compare and neighbor fetch, slope multiply, a
// 5-stage divider retiring 2 quotient bits per stage, and the output register. It
// takes one word per cycle while i_out_stall is low.
// Reset clears the table to zero, sets offset 0, step 50, entries used 32, and empties
// the pipeline. While i_out_stall is high the output holds and other stages only fill
// bubbles; o_in_stall rises once the pipeline is full. No word is lost or repeated.
module ntc_table_interpolator_unit
    import ntc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADC_BITS    = ADC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_cmd,
    input  logic [TIDX_W-1:0]        i_table_index,
    input  logic [ADC_BITS-1:0]      i_table_value,
    input  logic [ADC_BITS-1:0]      i_adc_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [TEMP_W-1:0] o_temperature_tenths,
    output logic                     o_out_of_range,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SUM_A  = IDX_W + STEP_W + 2;
    localparam int SUM_W  = (SUM_A > TEMP_W + 1) ? SUM_A : TEMP_W + 1;
    localparam int PROD_W = ADC_BITS + STEP_W;
    localparam int SIDE_W = SUM_W + 1;

    t_cfg r_cfg;

    logic in_accept;
    logic srch_ready;
    logic srch_valid;
    logic [IDX_W-1:0]    srch_index;
    logic [ADC_BITS-1:0] srch_hi;
    logic [ADC_BITS-1:0] srch_lo;
    logic [ADC_BITS-1:0] srch_sample;
    logic                srch_oor;

    logic [ADC_BITS-1:0]       n_num;
    logic [ADC_BITS-1:0]       n_den;
    logic [PROD_W-1:0]         n_prod;
    logic [IDX_W-1:0]          n_im1;
    logic [IDX_W+STEP_W-1:0]   n_bprod;
    logic signed [SUM_W-1:0]   n_base;

    logic                    r_s3_valid;
    logic [ADC_BITS-1:0]     r_s3_den;
    logic [PROD_W-1:0]       r_s3_prod;
    logic signed [SUM_W-1:0] r_s3_base;
    logic                    r_s3_oor;
    logic                    s3_free;

    logic                    div_ready;
    logic                    div_valid;
    logic [STEP_W-1:0]       div_quot;
    logic [SIDE_W-1:0]       div_side;
    logic signed [SUM_W-1:0] div_base;
    logic                    div_oor;

    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  sat_hi;
    logic signed [SUM_W-1:0]  sat_lo;
    logic signed [TEMP_W-1:0] n_temp;

    logic                     r_out_valid;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic                     r_out_oor;
    logic                     out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset  <= OFFSET_RST;
            r_cfg.step    <= STEP_RST;
            r_cfg.entries <= EU_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_OFFSET:  r_cfg.offset  <= i_cfg_data[OFFSET_W-1:0];
                CFG_TEMP_STEP:    r_cfg.step    <= i_cfg_data[STEP_W-1:0];
                CFG_ENTRIES_USED: r_cfg.entries <= i_cfg_data[EU_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = !srch_ready;
    assign in_accept  = i_in_valid && srch_ready;

    ntc_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADC_BITS    (ADC_BITS),
        .IDX_W       (IDX_W)
    ) u_search (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_en    (in_accept && (t_cmd'(i_cmd) == CMD_LOAD)),
        .i_load_index (i_table_index),
        .i_load_value (i_table_value),
        .i_conv_valid (in_accept && (t_cmd'(i_cmd) == CMD_CONVERT)),
        .i_sample     (i_adc_sample),
        .i_cfg        (r_cfg),
        .o_ready      (srch_ready),
        .o_valid      (srch_valid),
        .i_ready      (s3_free),
        .o_index      (srch_index),
        .o_hi         (srch_hi),
        .o_lo         (srch_lo),
        .o_sample     (srch_sample),
        .o_oor        (srch_oor)
    );

    always_comb begin
        n_num   = srch_hi - srch_sample;
        n_den   = srch_hi - srch_lo;
        n_prod  = PROD_W'(n_num) * PROD_W'(r_cfg.step);
        n_im1   = srch_index - IDX_W'(1);
        n_bprod = (IDX_W + STEP_W)'(n_im1) * (IDX_W + STEP_W)'(r_cfg.step);
        n_base  = $signed(SUM_W'(n_bprod)) + SUM_W'(r_cfg.offset);
    end

    assign s3_free = !r_s3_valid || div_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_free) begin
            r_s3_valid <= srch_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free && srch_valid) begin
            r_s3_den  <= n_den;
            r_s3_prod <= n_prod;
            r_s3_base <= n_base;
            r_s3_oor  <= srch_oor;
        end
    end

    ntc_div #(
        .DEN_W  (ADC_BITS),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s3_valid),
        .o_ready    (div_ready),
        .i_dividend (r_s3_prod),
        .i_divisor  (r_s3_den),
        .i_side     ({r_s3_oor, r_s3_base}),
        .o_valid    (div_valid),
        .i_ready    (out_free),
        .o_quot     (div_quot),
        .o_side     (div_side)
    );

    assign div_base = $signed(div_side[SUM_W-1:0]);
    assign div_oor  = div_side[SUM_W];

    assign sat_hi = SUM_W'(TEMP_MAX);
    assign sat_lo = SUM_W'(TEMP_MIN);

    always_comb begin
        n_sum = $signed(SUM_W'(div_quot)) + div_base;
        if (div_oor) begin
            n_temp = '0;
        end else if (n_sum > sat_hi) begin
            n_temp = TEMP_MAX;
        end else if (n_sum < sat_lo) begin
            n_temp = TEMP_MIN;
        end else begin
            n_temp = n_sum[TEMP_W-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && div_valid) begin
            r_out_temp <= n_temp;
            r_out_oor  <= div_oor;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_temperature_tenths = r_out_temp;
    assign o_out_of_range       = r_out_oor;

endmodule

// ===== verif/ntc_table_interpolator_unit_test.sv =====
// Self-checking testbench for the NTC table interpolator: directed rows, then random table loads and conversions.
module ntc_table_interpolator_unit_test;
    import ntc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADC_W        = ADC_BITS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1320;
    localparam int QUIET_WORDS  = 1120;
    localparam int DRAIN_CYCLES = 12;
    localparam int NUM_DIR_ROWS = 27;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        t_cmd                       cmd;
        logic [TIDX_W-1:0]          idx;
        logic [ADC_W-1:0]           value;
        logic [ADC_W-1:0]           adc_val;
        logic signed [OFFSET_W-1:0] offset;
        logic [STEP_W-1:0]          step_sz;
        logic [EU_W-1:0]            entries;
        logic                       typed;
        logic signed [TEMP_W-1:0]   temp;
        logic                       oor;
    } t_stim_row;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     oor;
    } t_reading;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_cmd = 1'b0;
    logic [TIDX_W-1:0]        i_table_index = '0;
    logic [ADC_W-1:0]         i_table_value = '0;
    logic [ADC_W-1:0]         i_adc_sample = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [TEMP_W-1:0] o_temperature_tenths;
    logic                     o_out_of_range;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    logic signed [OFFSET_W-1:0] cur_offset = OFFSET_RST;
    logic [STEP_W-1:0]          cur_step = STEP_RST;
    logic [EU_W-1:0]            cur_entries = EU_RST;
    logic [ADC_W-1:0]           cal_tbl [TABLE_DEPTH_DEF];

    t_reading pending_readings [$];
    int       error_count = 0;
    int       items_sent = 0;
    int       cycle_count = 0;
    int       stall_left = 0;
    bit       bursts_on = 1'b0;

    t_stim_row dir_rows [NUM_DIR_ROWS] = '{
        '{ROW_WORD, CMD_CONVERT, 0, 0, 0, 0, 0, 0, 1, 0, 1},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 1023, 0, 0, 0, 1, 0, 1},
        '{ROW_WORD, CMD_LOAD, 0, 1023, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WORD, CMD_LOAD, 1, 512, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WORD, CMD_LOAD, 2, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 1023, 0, 0, 0, 1, 0, 1},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 1022, 0, 0, 0, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 512, 0, 0, 0, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CMD_LOAD, 0, 0, 0, 0, 50, 2, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 0, 0, 0, 0, 1, 0, 1},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 600, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CMD_LOAD, 0, 0, 0, 0, 50, 1, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 600, 0, 0, 0, 1, 0, 1},
        '{ROW_CFG, CMD_LOAD, 0, 0, 0, 0, 50, 0, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 0, 0, 0, 0, 1, 0, 1},
        '{ROW_CFG, CMD_LOAD, 0, 0, 0, -2048, 0, 32, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 0, 0, 0, 0, 1, -2048, 0},
        '{ROW_WORD, CMD_LOAD, 0, 100, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CMD_LOAD, 0, 0, 0, 5, 7, 32, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 50, 0, 0, 0, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 100, 0, 0, 0, 1, 0, 1},
        '{ROW_WORD, CMD_LOAD, 31, 1023, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 300, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CMD_LOAD, 0, 0, 0, 2047, 1023, 33, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 1, 0, 0, 0, 0, 0, 0},
        '{ROW_WORD, CMD_CONVERT, 0, 0, 511, 0, 0, 0, 0, 0, 0}
    };

    ntc_table_interpolator_unit u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_cmd                (i_cmd),
        .i_table_index        (i_table_index),
        .i_table_value        (i_table_value),
        .i_adc_sample         (i_adc_sample),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_temperature_tenths (o_temperature_tenths),
        .o_out_of_range       (o_out_of_range),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_reading convert_reading(logic [ADC_W-1:0] adc_val);
        t_reading r;
        int       n;
        int       k;
        longint   s;
        longint   hi;
        longint   lo;
        longint   st;
        longint   off;
        longint   t;
        n   = (int'(cur_entries) > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(cur_entries);
        s   = longint'(adc_val);
        st  = longint'(cur_step);
        off = longint'(cur_offset);
        k   = 0;
        while (k < n && s < longint'(cal_tbl[k])) k++;
        if (k == 0 || k == n) begin
            r.temp = '0;
            r.oor  = 1'b1;
        end else begin
            hi = longint'(cal_tbl[k-1]);
            lo = longint'(cal_tbl[k]);
            t  = ((hi - s) * st) / (hi - lo) + longint'(k - 1) * st + off;
            if (t > longint'(TEMP_MAX)) t = longint'(TEMP_MAX);
            if (t < longint'(TEMP_MIN)) t = longint'(TEMP_MIN);
            r.temp = TEMP_W'(t);
            r.oor  = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= 40) begin
            $display("%0t ERROR %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    task automatic check_reading(logic signed [TEMP_W-1:0] temp, logic oor);
        t_reading want;
        if (pending_readings.size() == 0) begin
            report_mismatch("result word with none pending", int'(temp), 0);
        end else begin
            want = pending_readings.pop_front();
            if (temp !== want.temp) report_mismatch("temperature_tenths", int'(temp), int'(want.temp));
            if (oor !== want.oor) report_mismatch("out_of_range", int'(oor), int'(want.oor));
        end
    endtask

    task automatic push_word(t_cmd cmd, logic [TIDX_W-1:0] idx, logic [ADC_W-1:0] value,
                             logic [ADC_W-1:0] adc_val, logic typed,
                             logic signed [TEMP_W-1:0] typed_temp, logic typed_oor);
        t_reading want;
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_table_index <= idx;
        i_table_value <= value;
        i_adc_sample  <= adc_val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (cmd == CMD_LOAD) begin
            if (idx < TABLE_DEPTH_DEF) cal_tbl[idx] = value;
        end else begin
            if (typed) begin
                want.temp = typed_temp;
                want.oor  = typed_oor;
            end else begin
                want = convert_reading(adc_val);
            end
            pending_readings.push_back(want);
        end
    endtask

    task automatic load_entry(logic [TIDX_W-1:0] idx, logic [ADC_W-1:0] value);
        push_word(CMD_LOAD, idx, value, ADC_W'($urandom), 1'b0, '0, 1'b0);
    endtask

    task automatic convert_sample(logic [ADC_W-1:0] adc_val);
        push_word(CMD_CONVERT, TIDX_W'($urandom), ADC_W'($urandom), adc_val, 1'b0, '0, 1'b0);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(logic signed [OFFSET_W-1:0] offset, logic [STEP_W-1:0] step_sz,
                                logic [EU_W-1:0] entries);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_TEMP_OFFSET;
        i_cfg_data  <= CFG_DATA_W'(offset);
        @(posedge i_clk);
        i_cfg_index <= CFG_TEMP_STEP;
        i_cfg_data  <= CFG_DATA_W'(step_sz);
        @(posedge i_clk);
        i_cfg_index <= CFG_ENTRIES_USED;
        i_cfg_data  <= CFG_DATA_W'(entries);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_offset  = offset;
        cur_step    = step_sz;
        cur_entries = entries;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_reading(o_temperature_tenths, o_out_of_range);
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) i_out_stall <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 6) == 0) begin
            stall_left  <= $urandom_range(1, 9);
            i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ntc_table_interpolator_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int                         r;
        int                         k;
        int                         n_used;
        int                         dec;
        int                         lvl;
        bit                         reverse;
        logic [ADC_W-1:0]           levels [TABLE_DEPTH_DEF];
        logic [ADC_W-1:0]           adc_val;
        logic signed [OFFSET_W-1:0] new_off;
        logic [STEP_W-1:0]          new_step;
        logic [EU_W-1:0]            new_ent;

        for (k = 0; k < TABLE_DEPTH_DEF; k++) cal_tbl[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        bursts_on = 1'b1;

        for (r = 0; r < NUM_DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_pipeline();
                apply_config(dir_rows[r].offset, dir_rows[r].step_sz, dir_rows[r].entries);
            end else begin
                push_word(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].value,
                          dir_rows[r].adc_val, dir_rows[r].typed, dir_rows[r].temp,
                          dir_rows[r].oor);
            end
        end

        while (items_sent < RANDOM_WORDS) begin
            drain_pipeline();
            bursts_on = (items_sent < QUIET_WORDS) && ($urandom_range(0, 4) != 0);

            case ($urandom_range(0, 7))
                0: new_off = -2048;
                1: new_off = -2000;
                2: new_off = 2000;
                3: new_off = 2047;
                4: new_off = 0;
                default: new_off = OFFSET_W'($urandom_range(0, 4000) - 2000);
            endcase
            case ($urandom_range(0, 7))
                0: new_step = 0;
                1: new_step = 1;
                2: new_step = 1000;
                3: new_step = 1023;
                default: new_step = STEP_W'($urandom_range(1, 1000));
            endcase
            case ($urandom_range(0, 7))
                0: new_ent = EU_W'($urandom_range(0, 1));
                1: new_ent = 32;
                2: new_ent = EU_W'($urandom_range(33, 63));
                3: new_ent = 2;
                default: new_ent = EU_W'($urandom_range(2, 32));
            endcase
            apply_config(new_off, new_step, new_ent);

            if ($urandom_range(0, 3) != 0) begin
                lvl = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(400, 1023);
                for (k = 0; k < TABLE_DEPTH_DEF; k++) begin
                    levels[k] = ADC_W'(lvl);
                    dec = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80)
                                                      : $urandom_range(0, 30);
                    lvl = (lvl > dec) ? lvl - dec : 0;
                end
                reverse = 1'($urandom_range(0, 1));
                for (k = 0; k < TABLE_DEPTH_DEF; k++) begin
                    if (reverse) load_entry(TIDX_W'(TABLE_DEPTH_DEF - 1 - k),
                                            levels[TABLE_DEPTH_DEF - 1 - k]);
                    else load_entry(TIDX_W'(k), levels[k]);
                end
            end else begin
                repeat ($urandom_range(0, 6)) load_entry(TIDX_W'($urandom), ADC_W'($urandom));
            end

            repeat ($urandom_range(8, 40)) begin
                if ($urandom_range(0, 9) == 0) begin
                    load_entry(TIDX_W'($urandom), ADC_W'($urandom));
                end else begin
                    n_used = (int'(cur_entries) > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF
                                                                   : int'(cur_entries);
                    case ($urandom_range(0, 9))
                        0, 1: adc_val = ADC_W'($urandom);
                        2: adc_val = (n_used > 0) ? cal_tbl[n_used - 1] : ADC_W'($urandom);
                        3: adc_val = (n_used > 0) ? cal_tbl[$urandom_range(0, n_used - 1)]
                                                  : ADC_W'($urandom);
                        default: adc_val = (n_used > 1)
                            ? ADC_W'($urandom_range(cal_tbl[0], cal_tbl[n_used - 1]))
                            : ADC_W'($urandom);
                    endcase
                    convert_sample(adc_val);
                end
            end
        end

        bursts_on = 1'b0;
        drain_pipeline();
        if (error_count == 0) begin
            $display("ntc_table_interpolator_unit: match");
        end else begin
            $display("ntc_table_interpolator_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== ntc_table_interpolator_unit.f =====
rtl/ntc_pkg.sv
rtl/ntc_search.sv
rtl/ntc_div.sv
rtl/ntc_table_interpolator_unit.sv
verif/ntc_table_interpolator_unit_test.sv
